[hdl/periodic_occupancy_conflict_check_top_assert.svh]
// Assertion macros of the occupancy conflict checker.
// Each macro checks a property on the rising edge of i_clk and is
// disabled while i_rst_n is low.
`ifndef PERIODIC_OCCUPANCY_CONFLICT_CHECK_TOP_ASSERT_SVH
`define PERIODIC_OCCUPANCY_CONFLICT_CHECK_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define POCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define POCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pocc_pkg.sv]
package pocc_pkg;

    // Field widths of one input item.
    localparam int GROUP_W   = 8;
    localparam int START_W   = 16;
    localparam int LATENCY_W = 5;
    localparam int PERIOD_W  = 12;
    localparam int COUNT_W   = 7;

    // Stream widths.
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic hit;
    } t_dp_sts;

endpackage

[hdl/pocc_dp.sv]
module pocc_dp #(
    parameter int MAX_COUNT   = 64,
    parameter int MAX_LATENCY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_same_op,
    input  logic [pocc_pkg::GROUP_W-1:0]      i_group_a,
    input  logic [pocc_pkg::START_W-1:0]      i_start_a,
    input  logic [pocc_pkg::LATENCY_W-1:0]    i_latency_a,
    input  logic [pocc_pkg::PERIOD_W-1:0]     i_period_a,
    input  logic [pocc_pkg::COUNT_W-1:0]      i_count_a,
    input  logic [pocc_pkg::GROUP_W-1:0]      i_group_b,
    input  logic [pocc_pkg::START_W-1:0]      i_start_b,
    input  logic [pocc_pkg::LATENCY_W-1:0]    i_latency_b,
    input  logic [pocc_pkg::PERIOD_W-1:0]     i_period_b,
    input  logic [pocc_pkg::COUNT_W-1:0]      i_count_b,
    input  pocc_pkg::t_dp_cmd                 i_cmd,
    output pocc_pkg::t_dp_sts                 o_sts
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam int LAT_W = $clog2(MAX_LATENCY + 1);
    // Largest start time reached: start + MAX_COUNT periods, plus a latency.
    localparam int POS_W = $clog2(65536 + MAX_COUNT * 4096 + MAX_LATENCY + 1);

    logic [POS_W-1:0]              r_a, r_b, n_a, n_b;
    logic [pocc_pkg::PERIOD_W-1:0] r_pa, r_pb;
    logic [LAT_W-1:0]              r_la, r_lb;
    logic [CNT_W-1:0]              r_ca, r_cb, r_i, r_j, n_i, n_j;

    logic [LAT_W-1:0]              lat_a_n, lat_b_n;
    logic [CNT_W-1:0]              cnt_a_n, cnt_b_n;
    logic [pocc_pkg::PERIOD_W-1:0] per_a_n, per_b_n;
    logic                          blocked;
    logic                          b_early;
    logic                          b_in_win;
    logic                          in_range;

    // Normalize latency and count of the incoming item.
    always_comb begin
        if (i_latency_a == '0) begin
            lat_a_n = LAT_W'(1);
        end else if (32'(i_latency_a) > MAX_LATENCY) begin
            lat_a_n = LAT_W'(MAX_LATENCY);
        end else begin
            lat_a_n = LAT_W'(i_latency_a);
        end
        if (i_latency_b == '0) begin
            lat_b_n = LAT_W'(1);
        end else if (32'(i_latency_b) > MAX_LATENCY) begin
            lat_b_n = LAT_W'(MAX_LATENCY);
        end else begin
            lat_b_n = LAT_W'(i_latency_b);
        end

        blocked = i_same_op ||
                  ((i_group_a != '0) && (i_group_b != '0) && (i_group_a != i_group_b));

        // A zero period means a single activation with any spacing.
        if (i_period_a == '0) begin
            per_a_n = pocc_pkg::PERIOD_W'(1);
            cnt_a_n = CNT_W'(1);
        end else begin
            per_a_n = i_period_a;
            if (32'(i_count_a) > MAX_COUNT) begin
                cnt_a_n = CNT_W'(MAX_COUNT);
            end else begin
                cnt_a_n = CNT_W'(i_count_a);
            end
        end
        if (i_period_b == '0) begin
            per_b_n = pocc_pkg::PERIOD_W'(1);
            cnt_b_n = CNT_W'(1);
        end else begin
            per_b_n = i_period_b;
            if (32'(i_count_b) > MAX_COUNT) begin
                cnt_b_n = CNT_W'(MAX_COUNT);
            end else begin
                cnt_b_n = CNT_W'(i_count_b);
            end
        end
        // Items that cannot conflict get an empty activation list for A.
        if (blocked) begin
            cnt_a_n = '0;
        end
    end

    // Two-pointer merge over the sorted activation starts of A and B.
    always_comb begin
        in_range = (r_i < r_ca) && (r_j < r_cb);
        // B activation ends before A activation starts.
        b_early  = (r_b + {{(POS_W-LAT_W){1'b0}}, r_lb}) <= r_a;
        // B activation starts before A activation ends.
        b_in_win = r_b < (r_a + {{(POS_W-LAT_W){1'b0}}, r_la});

        o_sts.hit  = in_range && !b_early && b_in_win;
        o_sts.done = !in_range || o_sts.hit;

        n_a = r_a;
        n_b = r_b;
        n_i = r_i;
        n_j = r_j;
        if (b_early) begin
            n_j = r_j + CNT_W'(1);
            n_b = r_b + {{(POS_W-pocc_pkg::PERIOD_W){1'b0}}, r_pb};
        end else begin
            n_i = r_i + CNT_W'(1);
            n_a = r_a + {{(POS_W-pocc_pkg::PERIOD_W){1'b0}}, r_pa};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= {{(POS_W-pocc_pkg::START_W){1'b0}}, i_start_a};
            r_b  <= {{(POS_W-pocc_pkg::START_W){1'b0}}, i_start_b};
            r_pa <= per_a_n;
            r_pb <= per_b_n;
            r_la <= lat_a_n;
            r_lb <= lat_b_n;
            r_ca <= cnt_a_n;
            r_cb <= cnt_b_n;
            r_i  <= '0;
            r_j  <= '0;
        end else if (i_cmd.step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_i <= n_i;
            r_j <= n_j;
        end
    end

endmodule

[hdl/pocc_ctrl.sv]
module pocc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  pocc_pkg::t_dp_sts  i_sts,
    input  logic               i_out_free,
    output pocc_pkg::t_dp_cmd  o_cmd,
    output logic               o_out_load
);

    `include "periodic_occupancy_conflict_check_top_assert.svh"

    pocc_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pocc_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    n_state = pocc_pkg::S_SCAN;
                end
            end
            pocc_pkg::S_SCAN: begin
                if (i_sts.done) begin
                    n_state = i_out_free ? pocc_pkg::S_IDLE : pocc_pkg::S_WAIT;
                end
            end
            pocc_pkg::S_WAIT: begin
                if (i_out_free) begin
                    n_state = pocc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pocc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready  = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            pocc_pkg::S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            pocc_pkg::S_SCAN: begin
                o_cmd.step = !i_sts.done;
                o_out_load = i_sts.done && i_out_free;
            end
            pocc_pkg::S_WAIT: begin
                o_out_load = i_out_free;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pocc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `POCC_ASSERT_SAME(a_out_needs_done, o_out_load, i_sts.done, "result handed off before scan finished")
    `POCC_ASSERT_NEXT(a_scan_continues, (r_state == pocc_pkg::S_SCAN) && !i_sts.done, r_state == pocc_pkg::S_SCAN, "scan left before it finished")
    `POCC_ASSERT_NEXT(a_wait_holds, (r_state == pocc_pkg::S_WAIT) && !i_out_free, r_state == pocc_pkg::S_WAIT && $stable(i_sts.hit), "pending result lost while output busy")

endmodule

[hdl/periodic_occupancy_conflict_check_top.sv]
// Periodic occupancy conflict checker. Each input item describes two periodic
// occupancies A and B of one resource (start, latency, period and activation
// count each, plus concurrency groups and a same-operation flag), and the block
// returns one item whose bit says whether some cycle is held by both while the
// two may run concurrently. The same-operation flag and two set, unequal groups
// force no conflict. A zero latency becomes the minimum, latencies and counts
// above MAX_LATENCY and MAX_COUNT saturate, and a zero period means a single
// activation. The check walks the sorted activation starts of A and B with two
// pointers, advancing one of them per clock. With the counts taken after
// saturation (a zero period counts as one activation), one item goes through
// a load, up to count_a + count_b - 1 merge steps, one per cycle until a hit
// or the end of either list, and the hand-off into the output register. One
// item is in the scan at a time; the next item is accepted as soon as the
// previous result sits in the output register, even if the downstream side
// has not taken it yet. A finished result waits in the scan while the output
// register still holds an untaken item, and the input stays closed for that
// time.
module periodic_occupancy_conflict_check_top #(
    parameter int MAX_COUNT   = 64,
    parameter int MAX_LATENCY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // From bit 0 up: group_a[8], start_a[16], latency_a[5], period_a[12],
    // count_a[7], group_b[8], start_b[16], latency_b[5], period_b[12], count_b[7].
    input  logic [pocc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // From bit 0 up: same_op[1].
    input  logic [pocc_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // From bit 0 up: conflict[1], then zero padding.
    output logic [pocc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    pocc_pkg::t_dp_cmd cmd;
    pocc_pkg::t_dp_sts sts;
    logic              out_free;
    logic              out_load;
    logic              r_m_valid;
    logic              r_conflict;

    // The output register is free when empty or when its item leaves now.
    assign out_free = !r_m_valid || i_m_axis_tready;

    pocc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .o_s_ready  (o_s_axis_tready),
        .i_sts      (sts),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .o_out_load (out_load)
    );

    // The datapath loads straight from the input bus on the accepting edge.
    pocc_dp #(
        .MAX_COUNT   (MAX_COUNT),
        .MAX_LATENCY (MAX_LATENCY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_same_op   (i_s_axis_tuser[0]),
        .i_group_a   (i_s_axis_tdata[7:0]),
        .i_start_a   (i_s_axis_tdata[23:8]),
        .i_latency_a (i_s_axis_tdata[28:24]),
        .i_period_a  (i_s_axis_tdata[40:29]),
        .i_count_a   (i_s_axis_tdata[47:41]),
        .i_group_b   (i_s_axis_tdata[55:48]),
        .i_start_b   (i_s_axis_tdata[71:56]),
        .i_latency_b (i_s_axis_tdata[76:72]),
        .i_period_b  (i_s_axis_tdata[88:77]),
        .i_count_b   (i_s_axis_tdata[95:89]),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_conflict <= sts.hit;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(pocc_pkg::M_TDATA_W-1){1'b0}}, r_conflict};

endmodule

[tb/tb_periodic_occupancy_conflict_check_top.sv]
`timescale 1ns / 1ps

module tb_periodic_occupancy_conflict_check_top;

    localparam int MAX_COUNT   = 64;
    localparam int MAX_LATENCY = 16;
    localparam int RAND_ITEMS  = 120;

    // One input item, as the predictor sees it.
    typedef struct packed {
        bit                           same_op;
        bit [pocc_pkg::GROUP_W-1:0]   group_a;
        bit [pocc_pkg::START_W-1:0]   start_a;
        bit [pocc_pkg::LATENCY_W-1:0] latency_a;
        bit [pocc_pkg::PERIOD_W-1:0]  period_a;
        bit [pocc_pkg::COUNT_W-1:0]   count_a;
        bit [pocc_pkg::GROUP_W-1:0]   group_b;
        bit [pocc_pkg::START_W-1:0]   start_b;
        bit [pocc_pkg::LATENCY_W-1:0] latency_b;
        bit [pocc_pkg::PERIOD_W-1:0]  period_b;
        bit [pocc_pkg::COUNT_W-1:0]   count_b;
    } t_occ_pair;

    // Scoreboard: works out the conflict bit of each accepted pair and
    // compares the results of the block with it in order.
    class t_conflict_tracker;
        bit          expected_conflicts[$];
        int unsigned failures;

        // Searches for a cycle held by both occupancies. For every
        // activation of A it finds the first activation of B that starts
        // late enough, and checks whether that one starts early enough.
        function bit predict_conflict(t_occ_pair p);
            longint sa, la, pa, ca, sb, lb, pb, cb;
            longint i, a, lo, hi, j;
            if (p.same_op)
                return 1'b0;
            if (p.group_a != 0 && p.group_b != 0 && p.group_a != p.group_b)
                return 1'b0;
            sa = longint'(p.start_a);
            sb = longint'(p.start_b);
            la = longint'(p.latency_a);
            lb = longint'(p.latency_b);
            pa = longint'(p.period_a);
            pb = longint'(p.period_b);
            ca = longint'(p.count_a);
            cb = longint'(p.count_b);
            // A zero latency becomes the minimum; long ones saturate.
            if (la == 0)
                la = 1;
            else if (la > MAX_LATENCY)
                la = longint'(MAX_LATENCY);
            if (lb == 0)
                lb = 1;
            else if (lb > MAX_LATENCY)
                lb = longint'(MAX_LATENCY);
            if (ca > MAX_COUNT)
                ca = longint'(MAX_COUNT);
            if (cb > MAX_COUNT)
                cb = longint'(MAX_COUNT);
            // A zero period is a single activation whatever the count.
            if (pa == 0) begin
                pa = 1;
                ca = 1;
            end
            if (pb == 0) begin
                pb = 1;
                cb = 1;
            end
            if (ca <= 0 || cb <= 0)
                return 1'b0;
            for (i = 0; i < ca; i++) begin
                a  = sa + i * pa;
                lo = a - lb + 1;
                hi = a + la - 1;
                j  = 0;
                if (lo > sb)
                    j = (lo - sb + pb - 1) / pb;
                if (j < cb && sb + j * pb <= hi)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_pair(t_occ_pair p);
            expected_conflicts.insert(expected_conflicts.size(), predict_conflict(p));
        endfunction

        function void check_conflict(bit got);
            bit want;
            if (expected_conflicts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result item: conflict %0b", got);
                return;
            end
            want = expected_conflicts.pop_front();
            if (want != got) begin
                failures++;
                if (failures <= 10)
                    $display("conflict mismatch: expected %0b, actual %0b", want, got);
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    // From bit 0 up: group_a, start_a, latency_a, period_a, count_a,
    // group_b, start_b, latency_b, period_b, count_b.
    logic [pocc_pkg::S_TDATA_W-1:0] i_s_axis_tdata;
    // From bit 0 up: same_op.
    logic [pocc_pkg::S_TUSER_W-1:0] i_s_axis_tuser;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    // From bit 0 up: conflict, then zero padding.
    logic [pocc_pkg::M_TDATA_W-1:0] o_m_axis_tdata;

    t_conflict_tracker tracker = new();
    t_occ_pair         driven_pair;
    int                idle_pct;

    periodic_occupancy_conflict_check_top #(
        .MAX_COUNT   (MAX_COUNT),
        .MAX_LATENCY (MAX_LATENCY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 10 ns clock.
    always #5 i_clk = ~i_clk;

    // The downstream side stalls at random, except while idle_pct is zero.
    // It changes only at the falling edge, so the block sees a stable value
    // at every rising edge.
    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(99) >= idle_pct);
    end

    // Both handshakes are sampled at the rising edge. An accepted pair is
    // handed to the predictor, an accepted result is checked against the
    // oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                tracker.note_pair(driven_pair);
            if (o_m_axis_tvalid && i_m_axis_tready)
                tracker.check_conflict(o_m_axis_tdata[0]);
        end
    end

    function automatic t_occ_pair make_pair(int same, int ga, int sa, int la, int pa, int ca,
                                            int gb, int sb, int lb, int pb, int cb);
        t_occ_pair p;
        p.same_op   = same[0];
        p.group_a   = pocc_pkg::GROUP_W'(ga);
        p.start_a   = pocc_pkg::START_W'(sa);
        p.latency_a = pocc_pkg::LATENCY_W'(la);
        p.period_a  = pocc_pkg::PERIOD_W'(pa);
        p.count_a   = pocc_pkg::COUNT_W'(ca);
        p.group_b   = pocc_pkg::GROUP_W'(gb);
        p.start_b   = pocc_pkg::START_W'(sb);
        p.latency_b = pocc_pkg::LATENCY_W'(lb);
        p.period_b  = pocc_pkg::PERIOD_W'(pb);
        p.count_b   = pocc_pkg::COUNT_W'(cb);
        return p;
    endfunction

    // Offers one item upstream. Random idle cycles come first, then tvalid
    // stays high until the block takes the item. tvalid is left high on
    // return, so it drops between items only when random idle cycles come first.
    task automatic send_pair(t_occ_pair p);
        bit go;
        go = 1'b0;
        while (!go) begin
            @(negedge i_clk);
            if ($urandom_range(99) < idle_pct)
                i_s_axis_tvalid = 1'b0;
            else
                go = 1'b1;
        end
        driven_pair     = p;
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = p.same_op;
        i_s_axis_tdata  = {p.count_b, p.period_b, p.latency_b, p.start_b, p.group_b,
                           p.count_a, p.period_a, p.latency_a, p.start_a, p.group_a};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
    endtask

    initial begin
        t_occ_pair p;
        int        offset;
        int        g;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        driven_pair     = '0;
        idle_pct        = 35;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: the arguments are same_op, then group, start,
        // latency, period and count of A, then the same for B.
        // Everything zero: two one-shot, one-cycle holds at cycle 0.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Overlapping holds of the same operation never conflict.
        send_pair(make_pair(1, 0, 100, 4, 0, 1, 0, 100, 4, 0, 1));
        // Two set groups that differ: never concurrent.
        send_pair(make_pair(0, 3, 100, 4, 0, 1, 7, 101, 4, 0, 1));
        // Equal groups may run together.
        send_pair(make_pair(0, 5, 100, 4, 0, 1, 5, 102, 4, 0, 1));
        // One group unset counts as possibly concurrent, both directions.
        send_pair(make_pair(0, 0, 100, 4, 0, 1, 9, 103, 4, 0, 1));
        send_pair(make_pair(0, 9, 100, 4, 0, 1, 0, 104, 4, 0, 1));
        // Zero latency becomes the minimum hold, so adjacent starts do not touch.
        send_pair(make_pair(0, 0, 200, 0, 0, 1, 0, 201, 0, 0, 1));
        // Longest latency reaching the last shared cycle.
        send_pair(make_pair(0, 0, 300, 16, 0, 1, 0, 315, 1, 0, 1));
        // Latency 31 saturates to 16 and ends just before B starts.
        send_pair(make_pair(0, 0, 300, 31, 0, 1, 0, 316, 1, 0, 1));
        // Zero period with a large count is still a single activation.
        send_pair(make_pair(0, 0, 1000, 2, 0, 64, 0, 1010, 2, 5, 3));
        // Count 127 saturates to 64, so the activation at 640 never comes.
        send_pair(make_pair(0, 0, 0, 1, 10, 127, 0, 640, 1, 0, 1));
        send_pair(make_pair(0, 0, 0, 1, 10, 64, 0, 630, 1, 0, 1));
        // Zero count with a period: no activation at all.
        send_pair(make_pair(0, 0, 500, 4, 10, 0, 0, 500, 4, 0, 1));
        // Zero count with zero period: one activation.
        send_pair(make_pair(0, 0, 500, 4, 0, 0, 0, 500, 4, 0, 1));
        // Two trains that meet, and two that can never meet.
        send_pair(make_pair(0, 0, 0, 1, 7, 64, 0, 3, 1, 11, 64));
        send_pair(make_pair(0, 0, 0, 1, 4, 64, 0, 1, 1, 6, 64));
        // Field extremes.
        send_pair(make_pair(0, 255, 65535, 31, 4095, 127,
                            255, 0, 31, 4095, 127));
        send_pair(make_pair(1, 255, 65535, 31, 4095, 127,
                            255, 65535, 31, 4095, 127));
        send_pair(make_pair(0, 255, 0, 16, 0, 1, 254, 0, 16, 0, 1));
        // A one-shot just before a periodic train.
        send_pair(make_pair(0, 0, 1000, 3, 50, 10, 0, 990, 0, 0, 1));
        send_pair(make_pair(0, 1, 0, 16, 33, 64, 1, 16, 16, 32, 64));

        // Random part. Most pairs sit close together so that both answers
        // come up often; the rest use every field at full range.
        for (int k = 0; k < RAND_ITEMS; k++) begin
            idle_pct = (k >= 50 && k < 90) ? 0 : 35;
            if ($urandom_range(99) < 20) begin
                p.same_op   = 1'($urandom_range(1));
                p.group_a   = pocc_pkg::GROUP_W'($urandom_range(255));
                p.start_a   = pocc_pkg::START_W'($urandom_range(65535));
                p.latency_a = pocc_pkg::LATENCY_W'($urandom_range(31));
                p.period_a  = pocc_pkg::PERIOD_W'($urandom_range(4095));
                p.count_a   = pocc_pkg::COUNT_W'($urandom_range(127));
                p.group_b   = pocc_pkg::GROUP_W'($urandom_range(255));
                p.start_b   = pocc_pkg::START_W'($urandom_range(65535));
                p.latency_b = pocc_pkg::LATENCY_W'($urandom_range(31));
                p.period_b  = pocc_pkg::PERIOD_W'($urandom_range(4095));
                p.count_b   = pocc_pkg::COUNT_W'($urandom_range(127));
            end else begin
                p.same_op = ($urandom_range(9) == 0);
                g = $urandom_range(1, 255);
                case ($urandom_range(3))
                    0: begin
                        p.group_a = '0;
                        p.group_b = pocc_pkg::GROUP_W'($urandom_range(255));
                    end
                    1: begin
                        p.group_a = pocc_pkg::GROUP_W'($urandom_range(255));
                        p.group_b = '0;
                    end
                    2: begin
                        p.group_a = pocc_pkg::GROUP_W'(g);
                        p.group_b = pocc_pkg::GROUP_W'(g);
                    end
                    default: begin
                        p.group_a = pocc_pkg::GROUP_W'($urandom_range(255));
                        p.group_b = pocc_pkg::GROUP_W'($urandom_range(255));
                    end
                endcase
                offset    = int'($urandom_range(400)) - 200;
                p.start_a = pocc_pkg::START_W'($urandom_range(65535));
                p.start_b = pocc_pkg::START_W'(int'(p.start_a) + offset);
                p.latency_a = ($urandom_range(9) == 0)
                              ? pocc_pkg::LATENCY_W'($urandom_range(17, 31))
                              : pocc_pkg::LATENCY_W'($urandom_range(16));
                p.latency_b = ($urandom_range(9) == 0)
                              ? pocc_pkg::LATENCY_W'($urandom_range(17, 31))
                              : pocc_pkg::LATENCY_W'($urandom_range(16));
                // Short periods mostly, some one-shots and some long ones.
                case ($urandom_range(9))
                    0:       p.period_a = '0;
                    1:       p.period_a = pocc_pkg::PERIOD_W'($urandom_range(4095));
                    default: p.period_a = pocc_pkg::PERIOD_W'($urandom_range(1, 64));
                endcase
                case ($urandom_range(9))
                    0:       p.period_b = '0;
                    1:       p.period_b = pocc_pkg::PERIOD_W'($urandom_range(4095));
                    default: p.period_b = pocc_pkg::PERIOD_W'($urandom_range(1, 64));
                endcase
                case ($urandom_range(9))
                    0:       p.count_a = '0;
                    1:       p.count_a = pocc_pkg::COUNT_W'($urandom_range(65, 127));
                    default: p.count_a = pocc_pkg::COUNT_W'($urandom_range(1, 64));
                endcase
                case ($urandom_range(9))
                    0:       p.count_b = '0;
                    1:       p.count_b = pocc_pkg::COUNT_W'($urandom_range(65, 127));
                    default: p.count_b = pocc_pkg::COUNT_W'($urandom_range(1, 64));
                endcase
            end
            send_pair(p);
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        idle_pct        = 35;

        // Drain the pending results, then give the block the length of one
        // full scan to show any stray extra result.
        while (tracker.expected_conflicts.size() != 0)
            @(posedge i_clk);
        repeat (2 * MAX_COUNT + 8) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.expected_conflicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
